/* design/indexed_doubly_linked_list_macros.svh */
// Assertion macros used by the checker of the indexed doubly linked list.
`ifndef INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH
`define INDEXED_DOUBLY_LINKED_LIST_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define IDLL_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define IDLL_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* design/idll_pkg.sv */
// Types and constants of the indexed doubly linked list.
package idll_pkg;

    localparam int MAX_SLOTS = 1024;
    localparam int SLOT_W    = 10;
    localparam int COUNT_W   = 11;
    localparam int ADDR_W    = $clog2(MAX_SLOTS);
    localparam int LINK_W    = $clog2(MAX_SLOTS + 1);

    localparam logic [LINK_W-1:0] NIL = LINK_W'(MAX_SLOTS);

    typedef enum logic {
        OP_APPEND = 1'b0,
        OP_REMOVE = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LINK,
        ST_CLEAN
    } state_t;

    typedef struct packed {
        op_t               operation;
        logic [SLOT_W-1:0] slot;
    } req_t;

    typedef struct packed {
        logic               list_empty;
        logic [SLOT_W-1:0]  first_slot;
        logic [SLOT_W-1:0]  last_slot;
        logic [COUNT_W-1:0] member_count;
    } rsp_t;

endpackage

/* design/idll_if.sv */
// Handshake channels of the indexed doubly linked list.
interface idll_req_if;
    import idll_pkg::*;

    logic valid;
    logic ready;
    req_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

interface idll_rsp_if;
    import idll_pkg::*;

    logic valid;
    logic ready;
    rsp_t payload;

    modport source (output valid, output payload, input ready);
    modport sink (input valid, input payload, output ready);
endinterface

/* design/indexed_doubly_linked_list.sv */
// Top level of the indexed doubly linked list over a slot memory.
//
// Channel   Dir   Item
// req       in    operation (append or remove) and slot index
// rsp       out   list_empty, first_slot, last_slot, member_count
//
// Each item goes through three steps: accept with link read, neighbor link write,
// and own link write with the result loaded into the output register.
// The number of steps is set by the single write port of each link memory.
// After reset the link memories are cleared; req is not ready then.
// A stalled rsp holds the block in its last step until the waiting rsp item is taken.
module indexed_doubly_linked_list (
    input  logic     clk,
    input  logic     rst_n,
    idll_req_if.sink req,
    idll_rsp_if.source rsp
);
    import idll_pkg::*;

    logic [LINK_W-1:0] next_mem [MAX_SLOTS];
    logic [LINK_W-1:0] prev_mem [MAX_SLOTS];

    state_t state_reg, state_next;

    logic [ADDR_W-1:0]  clr_cnt_reg, clr_cnt_next;
    logic [LINK_W-1:0]  head_reg, head_next;
    logic [LINK_W-1:0]  tail_reg, tail_next;
    logic [COUNT_W-1:0] count_reg, count_next;

    op_t               op_reg;
    logic [ADDR_W-1:0] slot_reg;
    logic              in_range_reg;
    logic [LINK_W-1:0] own_prev_reg, own_prev_next;
    logic [LINK_W-1:0] next_rd_reg;
    logic [LINK_W-1:0] prev_rd_reg;

    logic              rsp_valid_reg;
    rsp_t              rsp_payload_reg, rsp_payload_next;

    logic              accept;
    logic              rsp_free;
    logic              load_rsp;

    logic              nxt_we;
    logic [ADDR_W-1:0] nxt_waddr;
    logic [LINK_W-1:0] nxt_wdata;
    logic              prv_we;
    logic [ADDR_W-1:0] prv_waddr;
    logic [LINK_W-1:0] prv_wdata;

    logic [LINK_W-1:0] slot_link;
    logic [LINK_W-1:0] p_link;
    logic [LINK_W-1:0] n_link;

    assign accept    = req.valid && req.ready;
    assign rsp_free  = !rsp_valid_reg || rsp.ready;
    assign slot_link = LINK_W'(slot_reg);
    assign p_link    = prev_rd_reg;
    assign n_link    = next_rd_reg;

    // Next state.
    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(MAX_SLOTS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_LINK;
                end
            end
            ST_LINK:
            begin
                state_next = ST_CLEAN;
            end
            ST_CLEAN:
            begin
                if (rsp_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    // Outputs, memory writes and list register updates.
    always_comb
    begin
        req.ready        = 1'b0;
        load_rsp         = 1'b0;
        nxt_we           = 1'b0;
        nxt_waddr        = slot_reg;
        nxt_wdata        = NIL;
        prv_we           = 1'b0;
        prv_waddr        = slot_reg;
        prv_wdata        = NIL;
        head_next        = head_reg;
        tail_next        = tail_reg;
        count_next       = count_reg;
        own_prev_next    = own_prev_reg;
        rsp_payload_next = rsp_payload_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                nxt_we    = 1'b1;
                nxt_waddr = clr_cnt_reg;
                prv_we    = 1'b1;
                prv_waddr = clr_cnt_reg;
            end
            ST_IDLE:
            begin
                req.ready = 1'b1;
            end
            ST_LINK:
            begin
                own_prev_next = NIL;
                if (in_range_reg)
                begin
                    if (op_reg == OP_APPEND)
                    begin
                        if (count_reg == '0)
                        begin
                            head_next = slot_link;
                        end
                        else
                        begin
                            own_prev_next = tail_reg;
                            nxt_we        = (tail_reg < NIL);
                            nxt_waddr     = ADDR_W'(tail_reg);
                            nxt_wdata     = slot_link;
                        end
                        tail_next = slot_link;
                        if (count_reg < COUNT_W'(MAX_SLOTS))
                        begin
                            count_next = count_reg + 1'b1;
                        end
                    end
                    else
                    begin
                        if (count_reg == COUNT_W'(1))
                        begin
                            head_next = NIL;
                            tail_next = NIL;
                        end
                        else if (slot_link == head_reg)
                        begin
                            prv_we    = (n_link < NIL);
                            prv_waddr = ADDR_W'(n_link);
                            prv_wdata = NIL;
                            head_next = n_link;
                        end
                        else if (slot_link == tail_reg)
                        begin
                            nxt_we    = (p_link < NIL);
                            nxt_waddr = ADDR_W'(p_link);
                            nxt_wdata = NIL;
                            tail_next = p_link;
                        end
                        else
                        begin
                            nxt_we    = (p_link < NIL);
                            nxt_waddr = ADDR_W'(p_link);
                            nxt_wdata = n_link;
                            prv_we    = (n_link < NIL);
                            prv_waddr = ADDR_W'(n_link);
                            prv_wdata = p_link;
                        end
                        if (count_reg != '0)
                        begin
                            count_next = count_reg - 1'b1;
                        end
                    end
                end
            end
            ST_CLEAN:
            begin
                nxt_we    = in_range_reg;
                nxt_waddr = slot_reg;
                nxt_wdata = NIL;
                prv_we    = in_range_reg;
                prv_waddr = slot_reg;
                prv_wdata = own_prev_reg;
                load_rsp  = rsp_free;
                rsp_payload_next.list_empty   = (count_reg == '0);
                rsp_payload_next.first_slot   = (head_reg < NIL) ? SLOT_W'(head_reg) : '0;
                rsp_payload_next.last_slot    = (tail_reg < NIL) ? SLOT_W'(tail_reg) : '0;
                rsp_payload_next.member_count = count_reg;
            end
            default:
            begin
                req.ready = 1'b0;
            end
        endcase
    end

    assign rsp.valid   = rsp_valid_reg;
    assign rsp.payload = rsp_payload_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            head_reg      <= NIL;
            tail_reg      <= NIL;
            count_reg     <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            clr_cnt_reg <= clr_cnt_next;
            head_reg    <= head_next;
            tail_reg    <= tail_next;
            count_reg   <= count_next;
            if (load_rsp)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg       <= req.payload.operation;
            slot_reg     <= ADDR_W'(req.payload.slot);
            in_range_reg <= (LINK_W'(req.payload.slot) < NIL);
        end
        own_prev_reg <= own_prev_next;
        if (load_rsp)
        begin
            rsp_payload_reg <= rsp_payload_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
        begin
            next_mem[nxt_waddr] <= nxt_wdata;
        end
        if (accept)
        begin
            next_rd_reg <= next_mem[ADDR_W'(req.payload.slot)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
        begin
            prev_mem[prv_waddr] <= prv_wdata;
        end
        if (accept)
        begin
            prev_rd_reg <= prev_mem[ADDR_W'(req.payload.slot)];
        end
    end

endmodule

/* design/idll_checker.sv */
// Port checker of the indexed doubly linked list and its bind statement.
`include "indexed_doubly_linked_list_macros.svh"

module idll_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          req_valid,
    input logic                          req_ready,
    input logic                          rsp_valid,
    input logic                          rsp_ready,
    input logic                          list_empty,
    input logic [idll_pkg::COUNT_W-1:0] member_count
);
    import idll_pkg::*;

    `IDLL_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_valid && !rsp_ready, rsp_valid, "rsp item dropped while stalled")
    `IDLL_ASSERT_NEXT(a_one_at_a_time, clk, rst_n, req_valid && req_ready, !req_ready, "req taken while an item is in work")
    `IDLL_ASSERT_NOW(a_empty_match, clk, rst_n, rsp_valid, list_empty == (member_count == '0), "list_empty disagrees with member_count")
    `IDLL_ASSERT_NOW(a_count_cap, clk, rst_n, rsp_valid, member_count <= COUNT_W'(MAX_SLOTS), "member_count beyond capacity")

endmodule

bind indexed_doubly_linked_list idll_checker u_idll_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .list_empty   (rsp.payload.list_empty),
    .member_count (rsp.payload.member_count)
);
